// File: rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition or implication checked at every edge
`define SGI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SGI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sgi_pkg.sv
package sgi_pkg;

  localparam int CoordW  = 32;
  localparam int DiffW   = CoordW + 1;        // coordinate difference
  localparam int ProdW   = 2 * DiffW;         // product of two differences
  localparam int CrsW    = ProdW + 1;         // den, tn, un
  localparam int Chunks  = 3;
  localparam int ChunkW  = (CrsW + Chunks - 1) / Chunks;
  localparam int PadW    = Chunks * ChunkW;
  localparam int PartW   = DiffW + ChunkW;    // one partial product
  localparam int BigW    = DiffW + CrsW;      // |d| * |tn|
  localparam int NumW    = BigW + 3;          // 2 * product + |den|
  localparam int DivW    = CrsW + 1;          // 2 * |den|
  localparam int QuoW    = CoordW + 2;        // quotient bits kept before saturation
  localparam int Lanes   = 4;
  localparam int FrontLat = 4;
  localparam int MulLat   = 2;
  localparam int DivLat   = QuoW + 2;
  localparam int Lat      = FrontLat + MulLat + DivLat;

  typedef struct packed {
    logic signed [CoordW-1:0] point_a_x;
    logic signed [CoordW-1:0] point_a_y;
    logic signed [CoordW-1:0] point_b_x;
    logic signed [CoordW-1:0] point_b_y;
    logic signed [CoordW-1:0] point_c_x;
    logic signed [CoordW-1:0] point_c_y;
    logic signed [CoordW-1:0] point_d_x;
    logic signed [CoordW-1:0] point_d_y;
  } in_word_t;

  typedef struct packed {
    logic                     is_parallel;
    logic                     segments_hit;
    logic signed [CoordW-1:0] cross_on_ab_x;
    logic signed [CoordW-1:0] cross_on_ab_y;
    logic signed [CoordW-1:0] cross_on_cd_x;
    logic signed [CoordW-1:0] cross_on_cd_y;
  } out_word_t;

  // lanes: ab_x, ab_y, cd_x, cd_y
  typedef struct packed {
    logic [Lanes-1:0][CoordW-1:0] base;
    logic [Lanes-1:0][DiffW-1:0]  dir_mag;
    logic [Lanes-1:0]             dir_neg;
    logic [CrsW-1:0]              den_mag;
    logic                         den_neg;
    logic [CrsW-1:0]              tn_mag;
    logic                         tn_neg;
    logic [CrsW-1:0]              un_mag;
    logic                         un_neg;
    logic                         parallel;
    logic                         hit;
  } geo_t;

  typedef struct packed {
    logic [NumW-1:0]   num;
    logic              neg;
    logic [CoordW-1:0] base;
  } lane_t;

  typedef struct packed {
    lane_t [Lanes-1:0] lane;
    logic [DivW-1:0]   d2;
    logic              parallel;
    logic              hit;
  } mul_t;

  typedef struct packed {
    logic parallel;
    logic hit;
  } meta_t;

endpackage

// File: rtl/core/sgi_front.sv
module sgi_front
  import sgi_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  in_word_t in_data,
  output geo_t     geo
);

  logic signed [DiffW-1:0] dx_r, dy_r, ex_r, ey_r, ox_r, oy_r;
  logic signed [DiffW-1:0] dx2_r, dy2_r, ex2_r, ey2_r;
  logic signed [DiffW-1:0] dx3_r, dy3_r, ex3_r, ey3_r;
  logic [Lanes-1:0][CoordW-1:0] base1_r, base2_r, base3_r;
  logic signed [ProdW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [CrsW-1:0]  den_r, tn_r, un_r;
  logic [CrsW-1:0]         den_mag, tn_mag, un_mag;
  logic                    tn_in, un_in;
  geo_t                    geo_nxt, geo_r;

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DiffW'($signed(in_data.point_b_x)) - DiffW'($signed(in_data.point_a_x));
      dy_r <= DiffW'($signed(in_data.point_b_y)) - DiffW'($signed(in_data.point_a_y));
      ex_r <= DiffW'($signed(in_data.point_d_x)) - DiffW'($signed(in_data.point_c_x));
      ey_r <= DiffW'($signed(in_data.point_d_y)) - DiffW'($signed(in_data.point_c_y));
      ox_r <= DiffW'($signed(in_data.point_a_x)) - DiffW'($signed(in_data.point_c_x));
      oy_r <= DiffW'($signed(in_data.point_a_y)) - DiffW'($signed(in_data.point_c_y));
      base1_r <= {in_data.point_a_x, in_data.point_a_y, in_data.point_c_x, in_data.point_c_y};
    end
  end

  // stage 2: cross products
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= ProdW'(ey_r) * ProdW'(dx_r);
      pb_r <= ProdW'(ex_r) * ProdW'(dy_r);
      pc_r <= ProdW'(ex_r) * ProdW'(oy_r);
      pd_r <= ProdW'(ey_r) * ProdW'(ox_r);
      pe_r <= ProdW'(oy_r) * ProdW'(dx_r);
      pf_r <= ProdW'(ox_r) * ProdW'(dy_r);
      dx2_r <= dx_r;
      dy2_r <= dy_r;
      ex2_r <= ex_r;
      ey2_r <= ey_r;
      base2_r <= base1_r;
    end
  end

  // stage 3: den, tn, un
  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= CrsW'(pa_r) - CrsW'(pb_r);
      tn_r  <= CrsW'(pc_r) - CrsW'(pd_r);
      un_r  <= CrsW'(pe_r) - CrsW'(pf_r);
      dx3_r <= dx2_r;
      dy3_r <= dy2_r;
      ex3_r <= ex2_r;
      ey3_r <= ey2_r;
      base3_r <= base2_r;
    end
  end

  // stage 4: sign and magnitude, exact range test
  always_comb begin
    den_mag = den_r[CrsW-1] ? CrsW'(-den_r) : CrsW'(den_r);
    tn_mag  = tn_r[CrsW-1]  ? CrsW'(-tn_r)  : CrsW'(tn_r);
    un_mag  = un_r[CrsW-1]  ? CrsW'(-un_r)  : CrsW'(un_r);
    tn_in   = ((tn_r == '0) || (tn_r[CrsW-1] == den_r[CrsW-1])) && (tn_mag <= den_mag);
    un_in   = ((un_r == '0) || (un_r[CrsW-1] == den_r[CrsW-1])) && (un_mag <= den_mag);
    geo_nxt.base       = base3_r;
    geo_nxt.dir_mag[3] = dx3_r[DiffW-1] ? DiffW'(-dx3_r) : DiffW'(dx3_r);
    geo_nxt.dir_mag[2] = dy3_r[DiffW-1] ? DiffW'(-dy3_r) : DiffW'(dy3_r);
    geo_nxt.dir_mag[1] = ex3_r[DiffW-1] ? DiffW'(-ex3_r) : DiffW'(ex3_r);
    geo_nxt.dir_mag[0] = ey3_r[DiffW-1] ? DiffW'(-ey3_r) : DiffW'(ey3_r);
    geo_nxt.dir_neg    = {dx3_r[DiffW-1], dy3_r[DiffW-1], ex3_r[DiffW-1], ey3_r[DiffW-1]};
    geo_nxt.den_mag    = den_mag;
    geo_nxt.den_neg    = den_r[CrsW-1];
    geo_nxt.tn_mag     = tn_mag;
    geo_nxt.tn_neg     = tn_r[CrsW-1];
    geo_nxt.un_mag     = un_mag;
    geo_nxt.un_neg     = un_r[CrsW-1];
    geo_nxt.parallel   = (den_r == '0);
    geo_nxt.hit        = tn_in && un_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r <= geo_nxt;
    end
  end

  assign geo = geo_r;

endmodule

// File: rtl/core/sgi_mul.sv
module sgi_mul
  import sgi_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  geo_t geo,
  output mul_t mo
);

  logic [Lanes-1:0][PadW-1:0]              nm_w;
  logic [Lanes-1:0][Chunks-1:0][PartW-1:0] pp_nxt, pp_r;
  logic [Lanes-1:0]                        neg_nxt, neg_r;
  logic [Lanes-1:0][CoordW-1:0]            base_r;
  logic [CrsW-1:0]                         den_mag_r;
  logic                                    parallel_r, hit_r;
  logic [Lanes-1:0][NumW-1:0]              acc_w;
  mul_t                                    mo_nxt, mo_r;

  // partial products of |dir| by slices of the numerator magnitude
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      nm_w[k]    = (k >= 2) ? PadW'(geo.tn_mag) : PadW'(geo.un_mag);
      neg_nxt[k] = geo.dir_neg[k] ^ geo.den_neg ^ ((k >= 2) ? geo.tn_neg : geo.un_neg);
      for (int j = 0; j < Chunks; j++) begin
        pp_nxt[k][j] = PartW'(geo.dir_mag[k]) * PartW'(nm_w[k][j*ChunkW +: ChunkW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r       <= pp_nxt;
      neg_r      <= neg_nxt;
      base_r     <= geo.base;
      den_mag_r  <= geo.den_mag;
      parallel_r <= geo.parallel;
      hit_r      <= geo.hit;
    end
  end

  // rounded dividend 2|n| + |den| against divisor 2|den|
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      acc_w[k] = '0;
      for (int j = 0; j < Chunks; j++) begin
        acc_w[k] = acc_w[k] + (NumW'(pp_r[k][j]) << (j * ChunkW));
      end
      mo_nxt.lane[k].num  = (acc_w[k] << 1) + NumW'(den_mag_r);
      mo_nxt.lane[k].neg  = neg_r[k];
      mo_nxt.lane[k].base = base_r[k];
    end
    mo_nxt.d2       = {den_mag_r, 1'b0};
    mo_nxt.parallel = parallel_r;
    mo_nxt.hit      = hit_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mo_r <= mo_nxt;
    end
  end

  assign mo = mo_r;

endmodule

// File: rtl/core/sgi_div.sv
module sgi_div
  import sgi_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  lane_t             lane_in,
  input  logic [DivW-1:0]   d2_in,
  output logic [CoordW-1:0] coord_out
);

  localparam int SumW = QuoW + 2;

  logic [NumW-1:0]   rem_r  [QuoW];
  logic [DivW-1:0]   d2_r   [QuoW];
  logic [QuoW-1:0]   quo_r  [QuoW+1];
  logic              neg_r  [QuoW+1];
  logic              ovf_r  [QuoW+1];
  logic [CoordW-1:0] base_r [QuoW+1];
  logic signed [SumW-1:0] sval, sum;
  logic [CoordW-1:0] coord_nxt, coord_r;

  // entry: quotient too large for the kept bits saturates outright
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= lane_in.num;
      d2_r[0]   <= d2_in;
      quo_r[0]  <= '0;
      neg_r[0]  <= lane_in.neg;
      ovf_r[0]  <= lane_in.num >= (NumW'(d2_in) << QuoW);
      base_r[0] <= lane_in.base;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar s = 1; s <= QuoW; s++) begin : g_step
    localparam int Bit = QuoW - s;
    logic [NumW-1:0] sh;
    logic            take;
    logic [QuoW-1:0] quo_nxt;

    always_comb begin
      sh      = NumW'(d2_r[s-1]) << Bit;
      take    = rem_r[s-1] >= sh;
      quo_nxt = quo_r[s-1];
      quo_nxt[Bit] = take;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s]  <= quo_nxt;
        neg_r[s]  <= neg_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        base_r[s] <= base_r[s-1];
      end
    end

    if (s < QuoW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= take ? rem_r[s-1] - sh : rem_r[s-1];
          d2_r[s]  <= d2_r[s-1];
        end
      end
    end
  end

  // add start coordinate, saturate
  always_comb begin
    sval = neg_r[QuoW] ? -$signed(SumW'(quo_r[QuoW])) : $signed(SumW'(quo_r[QuoW]));
    sum  = SumW'($signed(base_r[QuoW])) + sval;
    if (ovf_r[QuoW]) begin
      coord_nxt = neg_r[QuoW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else if ((&sum[SumW-1:CoordW-1]) || !(|sum[SumW-1:CoordW-1])) begin
      coord_nxt = sum[CoordW-1:0];
    end else begin
      coord_nxt = sum[SumW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord_out = coord_r;

endmodule

// File: rtl/core/segment_intersect_2d_unit.sv
// Intersection of segment AB with segment CD in signed Q15.16. One word is
// accepted per cycle while no stalled result holds the pipeline, and each
// gives one result word through the front, multiplier and divider stages;
// the divider, the deepest part, resolves one quotient bit per stage for each of
// the four point coordinates. Cross products, numerators and the [0,1] range
// test are exact; points are rounded to nearest, ties away from zero, and
// saturated. Parallel or degenerate lines give is_parallel, no hit and zero
// points. A stalled result holds the pipeline; in_stall is high only then.
module segment_intersect_2d_unit
  import sgi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic                         en;
  geo_t                         geo;
  mul_t                         mo;
  logic [Lanes-1:0][CoordW-1:0] coord;
  logic [Lat-1:0]               vld_r;
  meta_t [DivLat-1:0]           meta_r;
  meta_t                        meta_in;

  assign in_stall  = out_valid && out_stall;
  assign en        = !in_stall;
  assign out_valid = vld_r[Lat-1];

  sgi_front u_front (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .geo     (geo)
  );

  sgi_mul u_mul (
    .clk (clk),
    .en  (en),
    .geo (geo),
    .mo  (mo)
  );

  for (genvar k = 0; k < Lanes; k++) begin : g_div
    sgi_div u_div (
      .clk       (clk),
      .en        (en),
      .lane_in   (mo.lane[k]),
      .d2_in     (mo.d2),
      .coord_out (coord[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  assign meta_in = '{parallel: mo.parallel, hit: mo.hit};

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r <= {meta_r[DivLat-2:0], meta_in};
    end
  end

  always_comb begin
    out_data.is_parallel  = meta_r[DivLat-1].parallel;
    out_data.segments_hit = meta_r[DivLat-1].hit && !meta_r[DivLat-1].parallel;
    if (meta_r[DivLat-1].parallel) begin
      out_data.cross_on_ab_x = '0;
      out_data.cross_on_ab_y = '0;
      out_data.cross_on_cd_x = '0;
      out_data.cross_on_cd_y = '0;
    end else begin
      out_data.cross_on_ab_x = coord[3];
      out_data.cross_on_ab_y = coord[2];
      out_data.cross_on_cd_x = coord[1];
      out_data.cross_on_cd_y = coord[0];
    end
  end

endmodule

// File: rtl/core/sgi_checker.sv
`include "assert_macros.svh"

module sgi_checker
  import sgi_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  logic pts_zero;

  assign pts_zero = (out_data.cross_on_ab_x == '0) && (out_data.cross_on_ab_y == '0) &&
                    (out_data.cross_on_cd_x == '0) && (out_data.cross_on_cd_y == '0);

  // a held word stays offered and unchanged
  `SGI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")
  `SGI_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled word changed")
  // the pipeline only backs up when the result side holds it
  `SGI_ASSERT(a_no_idle_stall, !out_valid |-> !in_stall, "input stalled with empty output")
  // parallel lines never hit and carry zero points
  `SGI_ASSERT(a_parallel_zero, out_valid && out_data.is_parallel |-> !out_data.segments_hit && pts_zero, "parallel word not cleared")

endmodule

bind segment_intersect_2d_unit sgi_checker u_sgi_checker (.*);

// File: sim/segment_intersect_2d_unit_checker.sv
module segment_intersect_2d_unit_checker
  import sgi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        fail_count,
  output int        words_pending
);

  typedef logic signed [127:0] wide_t;

  out_word_t crossing_q[$];

  initial begin
    fail_count = 0;
    words_pending = 0;
  end

  function automatic wide_t mag(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // nearest step, ties away from zero
  function automatic wide_t div_round(wide_t n, wide_t d);
    wide_t q;
    q = (2 * mag(n) + mag(d)) / (2 * mag(d));
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic logic [CoordW-1:0] clamp_coord(wide_t v);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (CoordW - 1)) - 1;
    lo = -(wide_t'(1) <<< (CoordW - 1));
    if (v > hi) return hi[CoordW-1:0];
    if (v < lo) return lo[CoordW-1:0];
    return v[CoordW-1:0];
  endfunction

  function automatic logic in_unit(wide_t num, wide_t den);
    if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
    return mag(num) <= mag(den);
  endfunction

  function automatic out_word_t predict_crossing(in_word_t w);
    out_word_t r;
    wide_t ax, ay, cx, cy, dx, dy, ex, ey, ox, oy, den, tn, un;
    ax = wide_t'(w.point_a_x);
    ay = wide_t'(w.point_a_y);
    cx = wide_t'(w.point_c_x);
    cy = wide_t'(w.point_c_y);
    dx = wide_t'(w.point_b_x) - ax;
    dy = wide_t'(w.point_b_y) - ay;
    ex = wide_t'(w.point_d_x) - cx;
    ey = wide_t'(w.point_d_y) - cy;
    ox = ax - cx;
    oy = ay - cy;
    den = ey * dx - ex * dy;
    r = '0;
    if (den == 0) begin
      r.is_parallel = 1'b1;
      return r;
    end
    tn = ex * oy - ey * ox;
    un = oy * dx - ox * dy;
    r.segments_hit = in_unit(tn, den) && in_unit(un, den);
    r.cross_on_ab_x = clamp_coord(ax + div_round(dx * tn, den));
    r.cross_on_ab_y = clamp_coord(ay + div_round(dy * tn, den));
    r.cross_on_cd_x = clamp_coord(cx + div_round(ex * un, den));
    r.cross_on_cd_y = clamp_coord(cy + div_round(ey * un, den));
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) crossing_q.push_back(predict_crossing(in_data));
      if (out_valid && !out_stall) begin
        if (crossing_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_data);
          fail_count++;
        end else begin
          want = crossing_q.pop_front();
          if (want.is_parallel !== out_data.is_parallel ||
              want.segments_hit !== out_data.segments_hit ||
              want.cross_on_ab_x !== out_data.cross_on_ab_x ||
              want.cross_on_ab_y !== out_data.cross_on_ab_y ||
              want.cross_on_cd_x !== out_data.cross_on_cd_x ||
              want.cross_on_cd_y !== out_data.cross_on_cd_y) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
            fail_count++;
          end
        end
      end
      words_pending = crossing_q.size();
    end
  end

endmodule

// File: sim/segment_intersect_2d_unit_test.sv
module segment_intersect_2d_unit_test;
  import sgi_pkg::*;

  localparam int CycleLimit = 200000;
  localparam logic signed [CoordW-1:0] MaxC = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] MinC = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [CoordW-1:0] One = 32'sh0001_0000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  int        fail_count;
  int        words_pending;
  int        cycle_count;
  logic      steady;

  segment_intersect_2d_unit u_dut (.*);

  segment_intersect_2d_unit_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    steady = 1'b0;
    cycle_count = 0;
  end

  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 31);
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("segment_intersect_2d_unit_test failed");
      $finish;
    end
  end

  // idle cycles drawn one at a time, about 31 of a hundred
  task automatic send_word(in_word_t w);
    if (!steady) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  function automatic in_word_t seg(int ax, int ay, int bx, int by,
                                   int cx, int cy, int dx, int dy);
    in_word_t w;
    w.point_a_x = ax; w.point_a_y = ay; w.point_b_x = bx; w.point_b_y = by;
    w.point_c_x = cx; w.point_c_y = cy; w.point_d_x = dx; w.point_d_y = dy;
    return w;
  endfunction

  function automatic logic [CoordW-1:0] corner_coord();
    case ($urandom_range(4))
      0: return MaxC;
      1: return MinC;
      2: return '0;
      3: return '1;
      default: return 1;
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    logic [CoordW-1:0] v [8];
    int kind, sx, sy, k;
    kind = $urandom_range(9);
    for (int i = 0; i < 8; i++) begin
      case (kind)
        0, 1, 2, 3, 4: v[i] = $signed($urandom_range(0, 2 * 65536 * 16)) - 65536 * 16;
        5, 6: v[i] = $urandom;
        7: v[i] = corner_coord();
        default: v[i] = $signed($urandom_range(0, 2000)) - 1000;
      endcase
    end
    // parallel segments: cd direction a multiple of ab
    if (kind == 8) begin
      sx = $signed(v[2]) - $signed(v[0]);
      sy = $signed(v[3]) - $signed(v[1]);
      k = $signed($urandom_range(0, 6)) - 3;
      v[6] = $signed(v[4]) + k * sx;
      v[7] = $signed(v[5]) + k * sy;
    end
    w = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
    return w;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // plain crossing, touching ends, collinear, degenerate
    send_word(seg(0, 0, 2*One, 2*One, 0, 2*One, 2*One, 0));
    send_word(seg(0, 0, One, 0, One, 0, One, One));
    send_word(seg(0, 0, One, 0, 0, 0, 0, One));
    send_word(seg(0, 0, One, One, 2*One, 2*One, 3*One, 3*One));
    send_word(seg(0, 0, 0, 0, One, One, 2*One, 0));
    send_word(seg(0, 0, 0, 0, 0, 0, 0, 0));
    send_word(seg(0, 0, One, 0, 2*One, -One, 2*One, One));
    send_word(seg(0, 0, One, 0, 0, One, One, One));
    // rounding ties and sub-step quotients
    send_word(seg(0, 0, 1, 0, 0, -1, 1, 1));
    send_word(seg(0, 0, 3, 0, 1, -1, 2, 1));
    send_word(seg(0, 0, -3, 1, -1, -1, -2, 1));
    // coordinate extremes, saturation
    send_word(seg(MinC, MinC, MaxC, MaxC, MinC, MaxC, MaxC, MinC));
    send_word(seg(MaxC, MaxC, MinC, MinC, MaxC, MinC, MinC, MaxC));
    send_word(seg(MinC, 0, MinC + 1, 1, MaxC, 0, MaxC - 1, 1));
    send_word(seg(0, 0, 1, 1, MaxC, MinC, MaxC, MinC + 1));
    send_word(seg(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC));
    send_word(seg(MinC, MinC, MinC, MaxC, MaxC, MinC, MinC, MinC));
    send_word(seg(-1, -1, 1, 1, -1, 1, 1, -1));
    send_word(seg(0, 0, 1, 2, 0, 1, 2, 1));
    for (int n = 0; n < 650; n++) begin
      steady = (n >= 200 && n < 320);
      if (n == 400) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
      end
      send_word(random_word());
    end
    in_valid <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (Lat + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("segment_intersect_2d_unit_test passed");
    end else begin
      $display("segment_intersect_2d_unit_test failed");
    end
    $finish;
  end

endmodule
